// ===== design/thmr_pkg.sv =====
// ---------------------------------------------------------------------------
// thmr_pkg
// Shared types and constants for the half merge reduce unit.
// ---------------------------------------------------------------------------
package thmr_pkg;

   localparam int CFG_W = 7;
   localparam int ID_W  = 32;
   localparam int KEY_W = 64;

   localparam logic [CFG_W-1:0] LEN_RESET = 7'd10;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_PARTNER = 1'b1;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_PARTNER,
      CMD_MERGE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic signed [ID_W-1:0]   id;
      logic        [KEY_W-1:0]  key;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic pop;
   } back_stat_type;

endpackage

// ===== design/thmr_front.sv =====
// ---------------------------------------------------------------------------
// thmr_front
// Accepts items, tracks fill counts and turns each item into a command.
// ---------------------------------------------------------------------------
module thmr_front #(
   parameter int AW = 6,
   parameter int CW = 7
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [CW-1:0]                   len_eff,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic signed [thmr_pkg::ID_W-1:0] req_item_id,
   input  logic [thmr_pkg::KEY_W-1:0]      req_item_key,
   input  logic                            q_full,
   output logic                            q_push,
   output thmr_pkg::cmd_type               q_cmd,
   output logic [AW-1:0]                   q_index
);
   import thmr_pkg::*;

   logic [CW-1:0] local_fill_ff, local_fill_in;
   logic [CW-1:0] partner_fill_ff, partner_fill_in;
   logic [CW-1:0] lidx, pidx, pnext;
   logic          run_done;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      lidx     = (local_fill_ff >= len_eff) ? '0 : local_fill_ff;
      pidx     = (partner_fill_ff >= len_eff) ? '0 : partner_fill_ff;
      pnext    = pidx + CW'(1);
      run_done = (pnext == len_eff);

      local_fill_in   = local_fill_ff;
      partner_fill_in = partner_fill_ff;
      q_cmd.id        = req_item_id;
      q_cmd.key       = req_item_key;
      q_cmd.kind      = CMD_LOAD;
      q_index         = lidx[AW-1:0];

      if (req_operation == OP_LOAD) begin
         local_fill_in = lidx + CW'(1);
      end else begin
         q_index = pidx[AW-1:0];
         if (run_done) begin
            // final partner entry: merge leaves a full local list
            q_cmd.kind      = CMD_MERGE;
            partner_fill_in = '0;
            local_fill_in   = len_eff;
         end else begin
            q_cmd.kind      = CMD_PARTNER;
            partner_fill_in = pnext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_fill_ff   <= '0;
         partner_fill_ff <= '0;
      end else if (q_push) begin
         local_fill_ff   <= local_fill_in;
         partner_fill_ff <= partner_fill_in;
      end
   end

endmodule

// ===== design/thmr_queue.sv =====
// ---------------------------------------------------------------------------
// thmr_queue
// Two-entry command queue between front and back.
// ---------------------------------------------------------------------------
module thmr_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         full,
   output logic         not_empty
);
   import thmr_pkg::*;

   logic [W-1:0] slot_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop)      count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

endmodule

// ===== design/thmr_back.sv =====
// ---------------------------------------------------------------------------
// thmr_back
// List memories, merge sequencer and result register.
// ---------------------------------------------------------------------------
module thmr_back #(
   parameter int MAX_LIST_LEN = 64,
   parameter int AW = 6,
   parameter int CW = 7
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [CW-1:0]                    len_eff,
   input  logic                             q_valid,
   input  thmr_pkg::cmd_type                q_cmd,
   input  logic [AW-1:0]                    q_index,
   output thmr_pkg::back_stat_type          stat,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [thmr_pkg::ID_W-1:0] rsp_result_id,
   output logic [thmr_pkg::KEY_W-1:0]       rsp_result_key,
   output logic                             rsp_last_of_run
);
   import thmr_pkg::*;

   localparam int HW = CW + 1;

   typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_STEP} state_type;

   state_type state_ff;
   logic [CW-1:0] a_ff, b_ff;
   logic [HW-1:0] h_ff;
   logic          rsp_valid_ff, rsp_last_ff;
   logic signed [ID_W-1:0] rsp_id_ff;
   logic [KEY_W-1:0]       rsp_key_ff;

   logic signed [ID_W-1:0] local_id_mem   [MAX_LIST_LEN];
   logic [KEY_W-1:0]       local_key_mem  [MAX_LIST_LEN];
   logic signed [ID_W-1:0] partner_id_mem [MAX_LIST_LEN];
   logic [KEY_W-1:0]       partner_key_mem[MAX_LIST_LEN];

   logic signed [ID_W-1:0] lid_rd_ff, pid_rd_ff;
   logic [KEY_W-1:0]       lkey_rd_ff, pkey_rd_ff;

   logic                   pop, a_done, b_done, take_local, emit_phase, out_free;
   logic                   step_go, last_step;
   logic [HW-1:0]          n_wide, k_wide;
   logic signed [ID_W-1:0] sel_id;
   logic [KEY_W-1:0]       sel_key;
   logic                   lwe, pwe;
   logic [AW-1:0]          lwa;
   logic signed [ID_W-1:0] lwd_id;
   logic [KEY_W-1:0]       lwd_key;

   always_comb begin
      pop        = (state_ff == ST_IDLE) && q_valid;
      n_wide     = {1'b0, len_eff};
      a_done     = (a_ff == len_eff);
      b_done     = (b_ff == len_eff);
      // equal keys: partner goes first
      take_local = b_done || (!a_done && (lkey_rd_ff < pkey_rd_ff));
      emit_phase = (h_ff >= n_wide);
      out_free   = !rsp_valid_ff || rsp_ready;
      step_go    = (state_ff == ST_STEP) && (!emit_phase || out_free);
      last_step  = (h_ff == ((n_wide << 1) - HW'(1)));
      k_wide     = h_ff - n_wide;
      sel_id     = take_local ? lid_rd_ff : pid_rd_ff;
      sel_key    = take_local ? lkey_rd_ff : pkey_rd_ff;

      lwe     = 1'b0;
      lwa     = q_index;
      lwd_id  = q_cmd.id;
      lwd_key = q_cmd.key;
      pwe     = 1'b0;
      if (pop) begin
         unique case (q_cmd.kind)
            CMD_LOAD:    lwe = 1'b1;
            CMD_PARTNER: pwe = 1'b1;
            CMD_MERGE:   pwe = 1'b1;
            default:     ;
         endcase
      end else if (step_go && emit_phase) begin
         // upper half overwrites entries already consumed
         lwe     = 1'b1;
         lwa     = k_wide[AW-1:0];
         lwd_id  = sel_id;
         lwd_key = sel_key;
      end
   end

   assign stat.busy = (state_ff != ST_IDLE);
   assign stat.pop  = pop;

   always_ff @(posedge clock) begin
      if (lwe) begin
         local_id_mem[lwa]  <= lwd_id;
         local_key_mem[lwa] <= lwd_key;
      end
      lid_rd_ff  <= local_id_mem[a_ff[AW-1:0]];
      lkey_rd_ff <= local_key_mem[a_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (pwe) begin
         partner_id_mem[q_index]  <= q_cmd.id;
         partner_key_mem[q_index] <= q_cmd.key;
      end
      pid_rd_ff  <= partner_id_mem[b_ff[AW-1:0]];
      pkey_rd_ff <= partner_key_mem[b_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         a_ff         <= '0;
         b_ff         <= '0;
         h_ff         <= '0;
      end else begin
         rsp_valid_ff <= (rsp_valid_ff && !rsp_ready) || (step_go && emit_phase);
         unique case (state_ff)
            ST_IDLE: begin
               if (pop && (q_cmd.kind == CMD_MERGE)) begin
                  a_ff     <= '0;
                  b_ff     <= '0;
                  h_ff     <= '0;
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_STEP;
            end
            ST_STEP: begin
               if (step_go) begin
                  if (take_local) a_ff <= a_ff + CW'(1);
                  else            b_ff <= b_ff + CW'(1);
                  h_ff <= h_ff + HW'(1);
                  if (emit_phase) begin
                     rsp_id_ff    <= sel_id;
                     rsp_key_ff   <= sel_key;
                     rsp_last_ff  <= last_step;
                  end
                  state_ff <= last_step ? ST_IDLE : ST_FETCH;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_id   = rsp_id_ff;
   assign rsp_result_key  = rsp_key_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

// ===== design/top_half_merge_reduce_unit.sv =====
// ---------------------------------------------------------------------------
// top_half_merge_reduce_unit
// Keep-top-half merge of a local (id, key) list with partner list runs.
// ---------------------------------------------------------------------------
//  channel | ports                                   | direction
//  req     | req_valid/ready, operation, item_id/key | in
//  rsp     | rsp_valid/ready, result_id/key, last    | out
//  csr     | csr_wr_en, csr_wr_data (list_length)    | in, write only
//
//  Load and partner items are taken one per cycle into a two-entry queue while
//  it is not full. The final partner item of a run starts a merge of 2*n steps,
//  each a memory fetch then a compare, n = list_length; the registered read of
//  each list memory makes the fetch a step of its own.
//  During a merge the queue fills and req_ready drops; result stalls hold the merge.
//  Synchronous reset clears fill counts, queue and sequencer; lists are not cleared.
// ---------------------------------------------------------------------------
module top_half_merge_reduce_unit #(
   parameter int MAX_LIST_LEN = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_operation,
   input  logic signed [thmr_pkg::ID_W-1:0] req_item_id,
   input  logic [thmr_pkg::KEY_W-1:0]       req_item_key,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [thmr_pkg::ID_W-1:0] rsp_result_id,
   output logic [thmr_pkg::KEY_W-1:0]       rsp_result_key,
   output logic                             rsp_last_of_run,
   input  logic                             csr_wr_en,
   input  logic [thmr_pkg::CFG_W-1:0]       csr_wr_data
);
   import thmr_pkg::*;

   localparam int AW = (MAX_LIST_LEN > 1) ? $clog2(MAX_LIST_LEN) : 1;
   localparam int CW = $clog2(MAX_LIST_LEN + 1);
   localparam int QW = AW + $bits(cmd_type);

   logic [CFG_W-1:0] csr_len_ff;
   logic [CW-1:0]    len_eff;
   logic             q_full, q_push, q_valid;
   cmd_type          f_cmd, b_cmd;
   logic [AW-1:0]    f_index, b_index;
   logic [QW-1:0]    q_out;
   back_stat_type    stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_len_ff <= LEN_RESET;
      end else if (csr_wr_en) begin
         csr_len_ff <= csr_wr_data;
      end
   end

   always_comb begin
      priority if (csr_len_ff == '0)
         len_eff = CW'(1);
      else if (csr_len_ff > CFG_W'(MAX_LIST_LEN))
         len_eff = CW'(MAX_LIST_LEN);
      else
         len_eff = csr_len_ff[CW-1:0];
   end

   thmr_front #(.AW(AW), .CW(CW)) u_front (
      .clock         (clock),
      .reset         (reset),
      .len_eff       (len_eff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_item_id   (req_item_id),
      .req_item_key  (req_item_key),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (f_cmd),
      .q_index       (f_index)
   );

   thmr_queue #(.W(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_index, f_cmd}),
      .pop       (stat.pop),
      .pop_data  (q_out),
      .full      (q_full),
      .not_empty (q_valid)
   );

   assign b_index = q_out[QW-1 -: AW];
   assign b_cmd   = q_out[$bits(cmd_type)-1:0];

   thmr_back #(.MAX_LIST_LEN(MAX_LIST_LEN), .AW(AW), .CW(CW)) u_back (
      .clock           (clock),
      .reset           (reset),
      .len_eff         (len_eff),
      .q_valid         (q_valid),
      .q_cmd           (b_cmd),
      .q_index         (b_index),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_id   (rsp_result_id),
      .rsp_result_key  (rsp_result_key),
      .rsp_last_of_run (rsp_last_of_run)
   );

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   a_accept_queued: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> q_valid)
      else $error("accepted transfer missing from queue");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      stat.pop |-> (q_valid && !stat.busy))
      else $error("pop from empty queue or during merge");
`endif

endmodule

// ===== verif/top_half_merge_reduce_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// top_half_merge_reduce_unit_test
// Drives load and partner runs into the half merge reduce unit and checks
// every kept (id, key, last) entry against a local model of the merge.
// A short table of directed rows comes first, then random phases, each with
// its own list length, mostly sorted runs with some unsorted noise.
// ---------------------------------------------------------------------------
module top_half_merge_reduce_unit_test;
   import thmr_pkg::*;

   localparam int LIST_MAX   = 64;
   localparam int SETTLE_CYC = 4 * LIST_MAX + 48;
   localparam int ITEM_GOAL  = 470;

   typedef struct packed {
      logic signed [ID_W-1:0] id;
      logic [KEY_W-1:0]       key;
      logic                   last;
   } kept_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef enum logic [1:0] {SHAPE_SPREAD, SHAPE_TIES, SHAPE_TOP, SHAPE_LOW} key_shape_type;

   typedef struct {
      row_kind_type           kind;
      logic [CFG_W-1:0]       len_val;
      logic                   op;
      logic signed [ID_W-1:0] id;
      logic [KEY_W-1:0]       key;
      bit                     typed;
      kept_type               want;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_operation;
   logic signed [ID_W-1:0] req_item_id;
   logic [KEY_W-1:0]       req_item_key;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic signed [ID_W-1:0] rsp_result_id;
   logic [KEY_W-1:0]       rsp_result_key;
   logic                   rsp_last_of_run;
   logic                   csr_wr_en;
   logic [CFG_W-1:0]       csr_wr_data;

   // model of the lists
   logic signed [ID_W-1:0] loc_id  [LIST_MAX];
   logic [KEY_W-1:0]       loc_key [LIST_MAX];
   bit                     loc_set [LIST_MAX];
   logic signed [ID_W-1:0] par_id  [LIST_MAX];
   logic [KEY_W-1:0]       par_key [LIST_MAX];
   int                     loc_fill;
   int                     par_fill;
   logic [CFG_W-1:0]       len_reg;

   kept_type     kept_q[$];
   kept_type     round_q[$];
   plan_row_type plan_q[$];

   bit calm = 1'b0;
   bit send_gappy = 1'b1;
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int len_writes = 0;
   int max_span = 0;
   int big_left = 1;

   top_half_merge_reduce_unit #(
      .MAX_LIST_LEN(LIST_MAX)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_item_id(req_item_id),
      .req_item_key(req_item_key),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_id(rsp_result_id),
      .rsp_result_key(rsp_result_key),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic int span_of(input logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > LIST_MAX) return LIST_MAX;
      return int'(v);
   endfunction

   function automatic kept_type make_kept(input logic signed [ID_W-1:0] id,
                                          input logic [KEY_W-1:0] key, input logic last);
      kept_type e;
      e.id = id;
      e.key = key;
      e.last = last;
      return e;
   endfunction

   // two-way merge, partner first on equal keys; upper half replaces the local list
   task automatic merge_top_half(input int n);
      kept_type merged [2*LIST_MAX];
      int a;
      int b;
      int h;
      a = 0;
      b = 0;
      h = 0;
      while (a < n || b < n) begin
         if (b >= n || (a < n && loc_key[a] < par_key[b])) begin
            merged[h] = make_kept(loc_id[a], loc_key[a], 1'b0);
            a++;
         end else begin
            merged[h] = make_kept(par_id[b], par_key[b], 1'b0);
            b++;
         end
         h++;
      end
      for (int k = 0; k < n; k++) begin
         loc_id[k] = merged[n+k].id;
         loc_key[k] = merged[n+k].key;
         loc_set[k] = 1'b1;
         round_q.push_back(make_kept(merged[n+k].id, merged[n+k].key, k == n - 1));
      end
   endtask

   task automatic predict_item(input logic op, input logic signed [ID_W-1:0] id,
                               input logic [KEY_W-1:0] key);
      int n;
      n = span_of(len_reg);
      round_q.delete();
      if (op == OP_LOAD) begin
         if (loc_fill >= n) loc_fill = 0;
         loc_id[loc_fill] = id;
         loc_key[loc_fill] = key;
         loc_set[loc_fill] = 1'b1;
         loc_fill++;
      end else begin
         if (par_fill >= n) par_fill = 0;
         par_id[par_fill] = id;
         par_key[par_fill] = key;
         par_fill++;
         if (par_fill >= n) begin
            merge_top_half(n);
            loc_fill = n;
            par_fill = 0;
         end
      end
   endtask

   // a merge must never read a local entry that was never written
   function automatic bit merge_is_safe();
      int n;
      int next_fill;
      n = span_of(len_reg);
      next_fill = (par_fill >= n) ? 1 : par_fill + 1;
      if (next_fill < n) return 1'b1;
      for (int k = 0; k < n; k++)
         if (!loc_set[k]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      if (errors <= 30)
         $display("ERROR at %0t: %s got %h want %h", $time, what, got, want);
   endtask

   task automatic send_item(input logic op, input logic signed [ID_W-1:0] id,
                            input logic [KEY_W-1:0] key, input bit typed, input kept_type want);
      logic op_now;
      op_now = op;
      if (op_now == OP_PARTNER && !merge_is_safe()) op_now = OP_LOAD;
      if (!calm && send_gappy && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op_now;
      req_item_id <= id;
      req_item_key <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(op_now, id, key);
      if (typed) kept_q.push_back(want);
      else foreach (round_q[i]) kept_q.push_back(round_q[i]);
      items_sent++;
   endtask

   task automatic send_plain(input logic op, input logic signed [ID_W-1:0] id,
                             input logic [KEY_W-1:0] key);
      send_item(op, id, key, 1'b0, '0);
   endtask

   // hold off until the block has drained, including queued loads
   task automatic settle();
      req_valid <= 1'b0;
      while (kept_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_len(input logic [CFG_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      len_reg = v;
      len_writes++;
      if (span_of(v) > max_span) max_span = span_of(v);
   endtask

   task automatic add_row(input row_kind_type kind, input int v, input logic op,
                          input logic signed [ID_W-1:0] id, input logic [KEY_W-1:0] key,
                          input int typed, input kept_type want);
      plan_row_type r;
      r.kind = kind;
      r.len_val = CFG_W'(v);
      r.op = op;
      r.id = id;
      r.key = key;
      r.typed = (typed != 0);
      r.want = want;
      plan_q.push_back(r);
   endtask

   task automatic build_plan();
      // length 10 out of reset: extremes of key and id, ties across the lists
      add_row(ROW_ITEM, 0, OP_LOAD, 0, 64'h0, 0, '0);
      add_row(ROW_ITEM, 0, OP_LOAD, -1, 64'h1, 0, '0);
      add_row(ROW_ITEM, 0, OP_LOAD, 32'sh7fffffff, 64'h5, 0, '0);
      add_row(ROW_ITEM, 0, OP_LOAD, 32'sh80000000, 64'h5, 0, '0);
      add_row(ROW_ITEM, 0, OP_LOAD, 12, 64'd100, 0, '0);
      add_row(ROW_ITEM, 0, OP_LOAD, 13, 64'h0000_0001_0000_0000, 0, '0);
      add_row(ROW_ITEM, 0, OP_LOAD, 14, 64'h0000_0100_0000_0000, 0, '0);
      add_row(ROW_ITEM, 0, OP_LOAD, 15, 64'h7fff_ffff_ffff_ffff, 0, '0);
      add_row(ROW_ITEM, 0, OP_LOAD, 16, 64'h8000_0000_0000_0000, 0, '0);
      add_row(ROW_ITEM, 0, OP_LOAD, 17, 64'hffff_ffff_ffff_fffe, 0, '0);
      add_row(ROW_ITEM, 0, OP_PARTNER, 101, 64'h0, 0, '0);
      add_row(ROW_ITEM, 0, OP_PARTNER, 102, 64'h5, 0, '0);
      add_row(ROW_ITEM, 0, OP_PARTNER, 103, 64'h5, 0, '0);
      add_row(ROW_ITEM, 0, OP_PARTNER, 104, 64'h7, 0, '0);
      add_row(ROW_ITEM, 0, OP_PARTNER, 105, 64'd100, 0, '0);
      add_row(ROW_ITEM, 0, OP_PARTNER, -2, 64'h0000_0001_0000_0000, 0, '0);
      add_row(ROW_ITEM, 0, OP_PARTNER, 32'sh80000000, 64'h8000_0000_0000_0000, 0, '0);
      add_row(ROW_ITEM, 0, OP_PARTNER, 32'sh7fffffff, 64'h8000_0000_0000_0000, 0, '0);
      add_row(ROW_ITEM, 0, OP_PARTNER, 106, 64'hffff_ffff_ffff_fffe, 0, '0);
      add_row(ROW_ITEM, 0, OP_PARTNER, 107, 64'hffff_ffff_ffff_ffff, 0, '0);
      // partial partner run, then the length drops below its fill count
      add_row(ROW_ITEM, 0, OP_PARTNER, 201, 64'h1, 0, '0);
      add_row(ROW_ITEM, 0, OP_PARTNER, 202, 64'h2, 0, '0);
      add_row(ROW_ITEM, 0, OP_PARTNER, 203, 64'h3, 0, '0);
      add_row(ROW_CSR, 0, OP_LOAD, 0, 64'h0, 0, '0);
      add_row(ROW_ITEM, 0, OP_PARTNER, 204, 64'h55aa_55aa_55aa_55aa, 0, '0);
      // length 1: full local list restarts, then min against max and a tie
      add_row(ROW_ITEM, 0, OP_LOAD, 32'sh80000000, 64'h0, 0, '0);
      add_row(ROW_ITEM, 0, OP_PARTNER, 32'sh7fffffff, 64'hffff_ffff_ffff_ffff, 1,
              make_kept(32'sh7fffffff, 64'hffff_ffff_ffff_ffff, 1'b1));
      add_row(ROW_ITEM, 0, OP_LOAD, 3, 64'h7, 0, '0);
      add_row(ROW_ITEM, 0, OP_PARTNER, -1, 64'h7, 1, make_kept(3, 64'h7, 1'b1));
   endtask

   function automatic logic [KEY_W-1:0] loose_key();
      case ($urandom_range(0, 5))
         0:       return '1;
         1:       return '0;
         2:       return 64'($urandom_range(0, 3));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_len();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return 7'($urandom_range(1, 8));
      if (r < 15) return 7'($urandom_range(9, 16));
      if (r < 17) return 7'd0;
      if (r < 19 || big_left == 0) return 7'($urandom_range(17, 32));
      big_left--;
      return 7'($urandom_range(65, 126));
   endfunction

   // one ascending run of n entries
   task automatic send_sorted_run(input logic op, input int n);
      logic [KEY_W-1:0] k;
      key_shape_type shape;
      shape = key_shape_type'($urandom_range(0, 3));
      case (shape)
         SHAPE_SPREAD, SHAPE_TIES: k = {$urandom, $urandom} >> 1;
         SHAPE_TOP:                k = '1 - 64'(2 * (n - 1));
         default:                  k = '0;
      endcase
      repeat (n) begin
         send_plain(op, $urandom, k);
         case (shape)
            SHAPE_SPREAD: k = k + ({$urandom, $urandom} >> 8);
            SHAPE_TIES:   k = k + 64'($urandom_range(0, 1));
            SHAPE_TOP:    k = k + 64'($urandom_range(0, 2));
            default:      k = k + 64'($urandom_range(0, 1000));
         endcase
      end
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] v);
      int n;
      int runs;
      bit need_load;
      settle();
      write_len(v);
      n = span_of(v);
      send_gappy = $urandom_range(0, 2) != 0;
      if ($urandom_range(0, 4) != 0) begin
         need_load = 1'b0;
         for (int k = 0; k < n; k++)
            if (!loc_set[k]) need_load = 1'b1;
         if (need_load || $urandom_range(0, 1)) send_sorted_run(OP_LOAD, n);
         runs = (n > 16) ? 1 : $urandom_range(1, 3);
         repeat (runs) begin
            send_sorted_run(OP_PARTNER, n);
            if ($urandom_range(0, 3) == 0) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (kept_q.size() != 0);
            end
         end
      end else begin
         // unsorted noise with mixed operations
         repeat ($urandom_range(1, 2 * n + 3))
            send_plain(1'($urandom_range(0, 1)), $urandom, loose_key());
      end
   endtask

   initial begin
      plan_row_type row;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_LOAD;
      req_item_id = '0;
      req_item_key = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      len_reg = LEN_RESET;
      loc_fill = 0;
      par_fill = 0;
      max_span = span_of(LEN_RESET);
      build_plan();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_q[i]) begin
         row = plan_q[i];
         if (row.kind == ROW_CSR) begin
            settle();
            write_len(row.len_val);
         end else begin
            send_item(row.op, row.id, row.key, row.typed, row.want);
         end
      end

      run_phase(7'd127);
      while (items_sent < ITEM_GOAL) begin
         calm = items_sent >= ITEM_GOAL - 70;
         run_phase(pick_len());
      end

      calm = 1'b1;
      req_valid <= 1'b0;
      do @(posedge clock); while (kept_q.size() != 0);
      repeat (SETTLE_CYC) @(posedge clock);
      $display("Ran %0d transfers in, %0d kept entries out, over %0d length writes",
               items_sent, results_seen, len_writes);
      $display("Lists of 1 to %0d entries, sorted runs, ties, key extremes and noise",
               max_span);
      if (errors == 0)
         $display("top_half_merge_reduce_unit: match");
      else
         $display("top_half_merge_reduce_unit: mismatch");
      $finish;
   end

   // result side: random stall bursts, steady in the tail of the run
   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat (calm ? 1 : $urandom_range(1, 24)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      kept_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (kept_q.size() == 0) begin
            report_mismatch("result with nothing expected, key", rsp_result_key, '0);
         end else begin
            due = kept_q.pop_front();
            if (rsp_result_id !== due.id)
               report_mismatch("result_id", 64'(rsp_result_id), 64'(due.id));
            if (rsp_result_key !== due.key)
               report_mismatch("result_key", rsp_result_key, due.key);
            if (rsp_last_of_run !== due.last)
               report_mismatch("last_of_run", 64'(rsp_last_of_run), 64'(due.last));
         end
      end
   end

   initial begin
      #4_000_000;
      $display("Timeout with %0d entries still expected", kept_q.size());
      $display("top_half_merge_reduce_unit: mismatch");
      $finish;
   end

endmodule
